### hw/rtl/sensor_anomaly_trend_checker_assert.svh
// Assertion macros for the sensor anomaly trend checker.
`ifndef SENSOR_ANOMALY_TREND_CHECKER_ASSERT_SVH
`define SENSOR_ANOMALY_TREND_CHECKER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SATC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("satc assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SATC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("satc assertion failed");

`endif

### hw/rtl/satc_pkg.sv
// Package with shared types and constants of the sensor anomaly trend checker.
`timescale 1ns / 1ps
`default_nettype none
package satc_pkg;

  localparam int unsigned WINDOW_DEF  = 10;
  localparam int unsigned MIN_FIT     = 3;
  localparam int unsigned NW          = 7;
  localparam logic [23:0] OFS_MAX     = 24'hFFFFFF;
  localparam logic [19:0] HORIZON_RST = 20'd300;
  localparam int unsigned EN_MIN      = 0;
  localparam int unsigned EN_MAX      = 1;
  localparam int unsigned EN_RATE     = 2;

  typedef enum logic [2:0] {
    CFG_MIN_LIMIT = 3'd0,
    CFG_MAX_LIMIT = 3'd1,
    CFG_MAX_RATE  = 3'd2,
    CFG_LIMIT_EN  = 3'd3,
    CFG_HORIZON   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {RA_NEWEST, RA_OLDEST, RA_WALK} ra_sel_e;

  typedef enum logic [2:0] {
    MS_N_SX2, MS_SX_SX, MS_N_SXY, MS_SX_SY, MS_NUM_NFX, MS_SY_DEN, MS_NUM_SX, MS_DEN_N
  } mul_sel_e;

  typedef enum logic [1:0] {MP_IDLE, MP_RUN, MP_FIX, MP_APPLY} mul_ph_e;
  typedef enum logic [1:0] {DP_IDLE, DP_RUN, DP_SAT} div_ph_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_NEW, ST_RATE, ST_T0, ST_W_RD, ST_W_X, ST_W_M, ST_W_A,
    ST_MUL_GO, ST_MUL_WAIT, ST_DEN_CHK, ST_DIV_GO, ST_DIV_WAIT, ST_FIN
  } state_e;

  typedef struct packed {
    logic     accept;
    ra_sel_e  ra_sel;
    logic     rate_chk;
    logic     t0_load;
    logic     walk_x;
    logic     walk_m;
    logic     walk_a;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     div_start;
    logic     pred_last;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic fit_ok;
    logic walk_last;
    logic mul_done;
    logic den_zero;
    logic div_done;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic signed [31:0] predicted_value;
    logic               prediction_valid;
    logic               predict_below_min;
    logic               predict_above_max;
    logic               rate_exceeded;
    logic               above_max;
    logic               below_min;
  } res_t;

endpackage
`default_nettype wire

### hw/rtl/satc_ctrl.sv
// Controller state machine that sequences the checker datapath.
`timescale 1ns / 1ps
`default_nettype none
module satc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_tvalid_i,
  output logic                  in_tready_o,
  input  wire satc_pkg::status_t sts_i,
  output satc_pkg::cmd_t        cmd_o
);
  import satc_pkg::*;

  state_e   state_q, state_d;
  mul_sel_e msel_q, msel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      msel_q  <= MS_N_SX2;
    end else begin
      state_q <= state_d;
      msel_q  <= msel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    msel_d  = msel_q;
    unique case (state_q)
      ST_IDLE:     if (in_tvalid_i) state_d = ST_RD_NEW;
      ST_RD_NEW:   state_d = ST_RATE;
      ST_RATE:     state_d = sts_i.fit_ok ? ST_T0 : ST_FIN;
      ST_T0:       state_d = ST_W_RD;
      ST_W_RD:     state_d = ST_W_X;
      ST_W_X:      state_d = ST_W_M;
      ST_W_M:      state_d = ST_W_A;
      ST_W_A: begin
        if (sts_i.walk_last) begin
          state_d = ST_MUL_GO;
          msel_d  = MS_N_SX2;
        end else begin
          state_d = ST_W_RD;
        end
      end
      ST_MUL_GO:   state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (sts_i.mul_done) begin
          priority if (msel_q == MS_SX_SX) begin
            state_d = ST_DEN_CHK;
          end else if (msel_q == MS_DEN_N) begin
            state_d = ST_DIV_GO;
          end else begin
            state_d = ST_MUL_GO;
            msel_d  = mul_sel_e'(msel_q + 3'd1);
          end
        end
      end
      ST_DEN_CHK: begin
        if (sts_i.den_zero) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MUL_GO;
          msel_d  = MS_N_SXY;
        end
      end
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (sts_i.div_done) state_d = ST_FIN;
      ST_FIN:      if (sts_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.ra_sel  = RA_WALK;
    cmd_o.mul_sel = msel_q;
    in_tready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_tready_o  = 1'b1;
        cmd_o.accept = in_tvalid_i;
      end
      ST_RD_NEW:  cmd_o.ra_sel = RA_NEWEST;
      ST_RATE: begin
        cmd_o.rate_chk = 1'b1;
        cmd_o.ra_sel   = RA_OLDEST;
      end
      ST_T0:      cmd_o.t0_load   = 1'b1;
      ST_W_X:     cmd_o.walk_x    = 1'b1;
      ST_W_M:     cmd_o.walk_m    = 1'b1;
      ST_W_A:     cmd_o.walk_a    = 1'b1;
      ST_MUL_GO:  cmd_o.mul_start = 1'b1;
      ST_DEN_CHK: cmd_o.pred_last = sts_i.den_zero;
      ST_DIV_GO:  cmd_o.div_start = 1'b1;
      ST_FIN:     cmd_o.finish    = sts_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/satc_dp.sv
// Datapath with sample history, fit sums, serial multiplier and divider.
`timescale 1ns / 1ps
`default_nettype none
module satc_dp #(
  parameter int unsigned WINDOW = satc_pkg::WINDOW_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic signed [31:0] sample_value_i,
  input  wire logic [31:0]        sample_time_i,
  input  wire satc_pkg::cmd_t     cmd_i,
  output satc_pkg::status_t       sts_o,
  output logic                    out_tvalid_o,
  input  wire logic               out_tready_i,
  output satc_pkg::res_t          res_o
);
  import satc_pkg::*;

  localparam int unsigned IdxW = $clog2(WINDOW);
  localparam int unsigned CntW = $clog2(WINDOW + 1);

  logic signed [31:0] min_q, max_q;
  logic [30:0]        rate_lim_q;
  logic [2:0]         en_q;
  logic [19:0]        hor_q;

  logic [63:0]        mem [WINDOW];
  logic [63:0]        rd_q;
  logic [IdxW-1:0]    raddr;
  logic [IdxW-1:0]    wslot_q, rp_q, newest, oldest;
  logic [CntW-1:0]    count_q;
  logic [CntW:0]      old_sum;
  logic [IdxW-1:0]    k_q;
  logic [NW-1:0]      n_w;

  logic signed [31:0] v_q, yl_q, y_q, pred_q;
  logic [31:0]        t_q, t0_q;
  logic [23:0]        x_q, xl_q, xw;
  logic               rate_q, out_valid_q;
  res_t               res_q;

  logic [31:0]         sx_q;
  logic signed [37:0]  sy_q;
  logic signed [63:0]  sxy_q;
  logic [63:0]         sx2_q;
  logic signed [56:0]  pxy_q;
  logic [47:0]         pxx_q;
  logic signed [127:0] den_q, num_q, top_q, bot_q;

  mul_ph_e             mph_q;
  logic [5:0]          mcnt_q;
  mul_sel_e            msel_q;
  logic                mneg_q;
  logic [127:0]        ma_q, macc_q, mp_q;
  logic [63:0]         mb_q;
  logic signed [127:0] op_a;
  logic signed [63:0]  op_b;
  logic [24:0]         fx;
  logic [31:0]         nfx;

  div_ph_e             dph_q;
  logic [6:0]          dcnt_q;
  logic                dneg_q;
  logic [127:0]        dq_q, dr_q, dr2;
  logic                dge;

  logic signed [32:0]  dt, dv, dv_mag;
  logic [31:0]         gap;
  logic [62:0]         rate_prod;
  logic                pam, pbm, fit;

  function automatic logic [31:0] sample_time_q_gap(input logic [31:0] a, input logic [31:0] b);
    sample_time_q_gap = a - b;
  endfunction

  assign n_w     = NW'(count_q);
  assign newest  = (wslot_q == '0) ? IdxW'(WINDOW - 1) : wslot_q - 1'b1;
  assign old_sum = (CntW+1)'(wslot_q) + (CntW+1)'(WINDOW) - (CntW+1)'(count_q);
  assign oldest  = (old_sum >= (CntW+1)'(WINDOW)) ? IdxW'(old_sum - (CntW+1)'(WINDOW))
                                                  : IdxW'(old_sum);
  assign fit     = count_q >= CntW'(MIN_FIT);

  always_comb begin
    unique case (cmd_i.ra_sel)
      RA_NEWEST: raddr = newest;
      RA_OLDEST: raddr = oldest;
      default:   raddr = rp_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[raddr];
    if (cmd_i.finish) mem[wslot_q] <= {t_q, v_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= 32'sh8000_0000;
      max_q      <= 32'sh7FFF_FFFF;
      rate_lim_q <= '0;
      en_q       <= '0;
      hor_q      <= HORIZON_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_LIMIT: min_q      <= cfg_wdata_i;
        CFG_MAX_LIMIT: max_q      <= cfg_wdata_i;
        CFG_MAX_RATE:  rate_lim_q <= cfg_wdata_i[30:0];
        CFG_LIMIT_EN:  en_q       <= cfg_wdata_i[2:0];
        CFG_HORIZON:   hor_q      <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  // Rate check against the newest stored sample.
  assign gap       = sample_time_q_gap(t_q, rd_q[63:32]);
  assign dv        = {v_q[31], v_q} - {rd_q[31], rd_q[31:0]};
  assign dv_mag    = dv[32] ? -dv : dv;
  assign rate_prod = 63'(rate_lim_q) * 63'(gap);

  assign dt = {1'b0, rd_q[63:32]} - {1'b0, t0_q};
  assign xw = dt[32] ? '0 : ((dt[31:24] != '0) ? OFS_MAX : dt[23:0]);

  assign fx  = 25'(xl_q) + 25'(hor_q);
  assign nfx = 32'(n_w) * 32'(fx);

  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_N_SX2:   begin op_a = 128'(sx2_q);         op_b = 64'(n_w);     end
      MS_SX_SX:   begin op_a = 128'(sx_q);          op_b = 64'(sx_q);    end
      MS_N_SXY:   begin op_a = 128'(sxy_q);         op_b = 64'(n_w);     end
      MS_SX_SY:   begin op_a = 128'(sy_q);          op_b = 64'(sx_q);    end
      MS_NUM_NFX: begin op_a = num_q;               op_b = 64'(nfx);     end
      MS_SY_DEN:  begin op_a = 128'(sy_q);          op_b = den_q[63:0];  end
      MS_NUM_SX:  begin op_a = num_q;               op_b = 64'(sx_q);    end
      default:    begin op_a = den_q;               op_b = 64'(n_w);     end
    endcase
  end

  assign dr2 = {dr_q[126:0], dq_q[127]};
  assign dge = dr2 >= bot_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      wslot_q     <= '0;
      out_valid_q <= 1'b0;
      mph_q       <= MP_IDLE;
      mcnt_q      <= '0;
      dph_q       <= DP_IDLE;
      dcnt_q      <= '0;
    end else begin
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        wslot_q     <= (wslot_q == IdxW'(WINDOW - 1)) ? '0 : wslot_q + 1'b1;
        if (count_q != CntW'(WINDOW)) count_q <= count_q + 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (mph_q)
        MP_IDLE: if (cmd_i.mul_start) begin
          mph_q  <= MP_RUN;
          mcnt_q <= '0;
        end
        MP_RUN: begin
          mcnt_q <= mcnt_q + 1'b1;
          if (mcnt_q == '1) mph_q <= MP_FIX;
        end
        MP_FIX:  mph_q <= MP_APPLY;
        default: mph_q <= MP_IDLE;
      endcase
      unique case (dph_q)
        DP_IDLE: if (cmd_i.div_start) begin
          dph_q  <= DP_RUN;
          dcnt_q <= '0;
        end
        DP_RUN: begin
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == '1) dph_q <= DP_SAT;
        end
        default: dph_q <= DP_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      v_q    <= sample_value_i;
      t_q    <= sample_time_i;
      pred_q <= '0;
    end
    if (cmd_i.rate_chk) begin
      rate_q <= en_q[EN_RATE] && (count_q != '0) && (t_q > rd_q[63:32])
                && (63'(dv_mag) > rate_prod);
    end
    if (cmd_i.t0_load) begin
      t0_q  <= rd_q[63:32];
      rp_q  <= oldest;
      k_q   <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      sx2_q <= '0;
    end
    if (cmd_i.walk_x) begin
      x_q  <= xw;
      xl_q <= xw;
      y_q  <= rd_q[31:0];
      yl_q <= rd_q[31:0];
      sx_q <= sx_q + 32'(xw);
      sy_q <= sy_q + 38'(signed'(rd_q[31:0]));
    end
    if (cmd_i.walk_m) begin
      pxy_q <= $signed({1'b0, x_q}) * y_q;
      pxx_q <= x_q * x_q;
    end
    if (cmd_i.walk_a) begin
      sxy_q <= sxy_q + 64'(pxy_q);
      sx2_q <= sx2_q + 64'(pxx_q);
      k_q   <= k_q + 1'b1;
      rp_q  <= (rp_q == IdxW'(WINDOW - 1)) ? '0 : rp_q + 1'b1;
    end
    if (cmd_i.pred_last) pred_q <= yl_q;

    unique case (mph_q)
      MP_IDLE: if (cmd_i.mul_start) begin
        msel_q <= cmd_i.mul_sel;
        mneg_q <= op_a[127] ^ op_b[63];
        ma_q   <= op_a[127] ? -op_a : op_a;
        mb_q   <= op_b[63] ? -op_b : op_b;
        macc_q <= '0;
      end
      MP_RUN: begin
        if (mb_q[0]) macc_q <= macc_q + ma_q;
        ma_q <= {ma_q[126:0], 1'b0};
        mb_q <= {1'b0, mb_q[63:1]};
      end
      MP_FIX: mp_q <= mneg_q ? -macc_q : macc_q;
      default: begin
        unique case (msel_q)
          MS_N_SX2:   den_q <= mp_q;
          MS_SX_SX:   den_q <= den_q - mp_q;
          MS_N_SXY:   num_q <= mp_q;
          MS_SX_SY:   num_q <= num_q - mp_q;
          MS_NUM_NFX: top_q <= mp_q;
          MS_SY_DEN:  top_q <= top_q + mp_q;
          MS_NUM_SX:  top_q <= top_q - mp_q;
          default:    bot_q <= mp_q;
        endcase
      end
    endcase

    unique case (dph_q)
      DP_IDLE: if (cmd_i.div_start) begin
        dneg_q <= top_q[127];
        dq_q   <= top_q[127] ? -top_q : top_q;
        dr_q   <= '0;
      end
      DP_RUN: begin
        dr_q <= dge ? dr2 - bot_q : dr2;
        dq_q <= {dq_q[126:0], dge};
      end
      default: begin
        if (!dneg_q) begin
          pred_q <= (dq_q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : dq_q[31:0];
        end else begin
          pred_q <= (dq_q > 128'h8000_0000) ? 32'sh8000_0000 : -dq_q[31:0];
        end
      end
    endcase

    if (cmd_i.finish) begin
      res_q.below_min         <= en_q[EN_MIN] && (v_q < min_q);
      res_q.above_max         <= en_q[EN_MAX] && (v_q > max_q);
      res_q.rate_exceeded     <= rate_q;
      res_q.predict_above_max <= pam;
      res_q.predict_below_min <= pbm;
      res_q.prediction_valid  <= fit;
      res_q.predicted_value   <= pred_q;
    end
  end

  assign pam = fit && en_q[EN_MAX] && (v_q <= max_q) && (pred_q > max_q);
  assign pbm = fit && !pam && en_q[EN_MIN] && (v_q >= min_q) && (pred_q < min_q);

  assign sts_o.fit_ok    = fit;
  assign sts_o.walk_last = (CntW'(k_q) == count_q - 1'b1);
  assign sts_o.mul_done  = (mph_q == MP_APPLY);
  assign sts_o.den_zero  = (den_q == '0);
  assign sts_o.div_done  = (dph_q == DP_SAT);
  assign sts_o.out_free  = !out_valid_q || out_tready_i;

  assign out_tvalid_o = out_valid_q;
  assign res_o        = res_q;

endmodule
`default_nettype wire

### hw/rtl/sensor_anomaly_trend_checker.sv
// Per beat, a walk over the n stored samples (n >= 3) builds the fit sums; eight serial
// multiplier passes and the divider form the prediction. Equal stored offsets end the fit
// after the second pass, and with fewer than three stored no fit is made. One beat is
// handled at a time; the next can be taken in the same cycle as the result turns valid.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst_ni low, asynchronous) empties the history and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module sensor_anomaly_trend_checker #(
  parameter int unsigned WINDOW = satc_pkg::WINDOW_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_tvalid_i,
  output logic             in_tready_o,
  input  wire logic [63:0] in_tdata_i,   // sample_value, sample_time
  output logic             out_tvalid_o,
  input  wire logic        out_tready_i,
  output logic [39:0]      out_tdata_o   // below_min, above_max, rate_exceeded,
                                         // predict_above_max, predict_below_min,
                                         // prediction_valid, predicted_value
);
  import satc_pkg::*;

  cmd_t    cmd;
  status_t sts;
  res_t    res;

  satc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (in_tvalid_i),
    .in_tready_o (in_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  satc_dp #(.WINDOW(WINDOW)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_value_i (in_tdata_i[31:0]),
    .sample_time_i  (in_tdata_i[63:32]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_tvalid_o   (out_tvalid_o),
    .out_tready_i   (out_tready_i),
    .res_o          (res)
  );

  assign out_tdata_o = {2'b00, res};

endmodule
`default_nettype wire

### hw/rtl/satc_checker.sv
// Port-level assertion checker for the sensor anomaly trend checker, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_anomaly_trend_checker_assert.svh"
module satc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic [2:0]  cfg_idx_i,
  input wire logic [31:0] cfg_wdata_i,
  input wire logic        in_tvalid_i,
  input wire logic        in_tready_o,
  input wire logic [63:0] in_tdata_i,
  input wire logic        out_tvalid_o,
  input wire logic        out_tready_i,
  input wire logic [39:0] out_tdata_o
);
  `SATC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_tvalid_o && !out_tready_i,
                   out_tvalid_o && $stable(out_tdata_o))
  `SATC_ASSERT_IMP(a_no_pred, clk_i, rst_ni, out_tvalid_o && !out_tdata_o[5],
                   out_tdata_o[37:6] == 32'd0 && !out_tdata_o[3] && !out_tdata_o[4])
  `SATC_ASSERT_IMP(a_pred_excl, clk_i, rst_ni, out_tvalid_o,
                   !(out_tdata_o[3] && out_tdata_o[4]))
  `SATC_ASSERT_IMP(a_min_excl, clk_i, rst_ni, out_tvalid_o,
                   !(out_tdata_o[0] && out_tdata_o[4]))
  `SATC_ASSERT_NXT(a_one_beat, clk_i, rst_ni, in_tvalid_i && in_tready_o, !in_tready_o)
endmodule

bind sensor_anomaly_trend_checker satc_checker u_satc_checker (.*);
`default_nettype wire

### bench/tb.sv
// Testbench for the sensor anomaly trend checker: predicted alarms and trend values per beat.
`timescale 1ns / 1ps
module tb;
  import satc_pkg::*;

  localparam int unsigned HIST      = 10;
  localparam logic [2:0]  CFG_UNUSED = 3'd7;
  localparam longint      CYC_LIMIT = 4000000;
  localparam int          DRAIN_CYC = 900;

  typedef logic signed [255:0] wide_t;
  typedef struct {
    logic signed [31:0] val;
    logic [31:0]        ts;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_tvalid_i = 1'b0;
  logic        in_tready_o;
  logic [63:0] in_tdata_i = '0;
  logic        out_tvalid_o;
  logic        out_tready_i = 1'b0;
  logic [39:0] out_tdata_o;

  sensor_anomaly_trend_checker uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the block's state and registers.
  logic signed [31:0] val_hist [HIST];
  logic [31:0]        ts_hist [HIST];
  int unsigned        fill_cnt = 0;
  int unsigned        wr_slot = 0;
  logic signed [31:0] lo_lim = 32'sh80000000;
  logic signed [31:0] hi_lim = 32'sh7FFFFFFF;
  logic [30:0]        rate_lim = '0;
  logic [2:0]         chk_en = '0;
  logic [19:0]        horizon = 20'd300;

  sample_t     sample_q[$];
  res_t        alarm_q[$];
  int          snd_idle = 0;
  int          rcv_idle = 0;
  int          err_cnt = 0;
  longint      cyc = 0;
  logic [31:0] now_ts = 0;

  function automatic logic signed [31:0] trend_value();
    wide_t n, sx, sy, sxy, sx2, x, y, den, fx, num, top, q, xl, yl;
    longint t0, xo;
    int unsigned old, idx;
    n = wide_t'(fill_cnt);
    old = (wr_slot + HIST - fill_cnt) % HIST;
    t0 = longint'({32'b0, ts_hist[old]});
    sx = 0; sy = 0; sxy = 0; sx2 = 0; xl = 0; yl = 0;
    for (int k = 0; k < fill_cnt; k++) begin
      idx = (old + k) % HIST;
      xo = longint'({32'b0, ts_hist[idx]}) - t0;
      if (xo < 0) xo = 0;
      if (xo > 64'hFFFFFF) xo = 64'hFFFFFF;
      x = wide_t'(xo);
      y = wide_t'(val_hist[idx]);
      sx += x; sy += y; sxy += x * y; sx2 += x * x;
      xl = x; yl = y;
    end
    den = n * sx2 - sx * sx;
    if (den == 0) return yl[31:0];
    fx = xl + wide_t'({1'b0, horizon});
    num = n * sxy - sx * sy;
    top = num * n * fx + sy * den - num * sx;
    q = top / (n * den);
    if (q > wide_t'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (q < -wide_t'(64'sh80000000)) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic res_t check_sample(logic signed [31:0] v, logic [31:0] t);
    res_t r;
    int unsigned nw;
    longint gap;
    longint dv;
    logic [63:0] mag;
    r = '0;
    r.below_min = chk_en[EN_MIN] && v < lo_lim;
    r.above_max = chk_en[EN_MAX] && v > hi_lim;
    if (chk_en[EN_RATE] && fill_cnt > 0) begin
      nw = (wr_slot + HIST - 1) % HIST;
      gap = longint'({32'b0, t}) - longint'({32'b0, ts_hist[nw]});
      if (gap > 0) begin
        dv = longint'(v) - longint'(val_hist[nw]);
        mag = dv < 0 ? -dv : dv;
        r.rate_exceeded = mag > {33'b0, rate_lim} * gap;
      end
    end
    if (fill_cnt >= MIN_FIT) begin
      r.prediction_valid = 1'b1;
      r.predicted_value = trend_value();
      if (chk_en[EN_MAX] && v <= hi_lim && r.predicted_value > hi_lim)
        r.predict_above_max = 1'b1;
      else if (chk_en[EN_MIN] && v >= lo_lim && r.predicted_value < lo_lim)
        r.predict_below_min = 1'b1;
    end
    val_hist[wr_slot] = v;
    ts_hist[wr_slot] = t;
    wr_slot = (wr_slot + 1) % HIST;
    if (fill_cnt < HIST) fill_cnt++;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cyc);
    err_cnt++;
  endtask

  // Stimulus driver.
  always @(posedge clk_i) begin
    if (!(in_tvalid_i && !in_tready_o)) begin
      if (sample_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
        in_tvalid_i <= 1'b1;
        in_tdata_i <= {sample_q[0].ts, sample_q[0].val};
        void'(sample_q.pop_front());
      end else begin
        in_tvalid_i <= 1'b0;
      end
    end
  end

  // Monitor: predicts on accepted input beats, checks output beats.
  always @(posedge clk_i) begin
    res_t want, got;
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    out_tready_i <= $urandom_range(99) >= rcv_idle;
    if (rst_ni && in_tvalid_i && in_tready_o)
      alarm_q.push_back(check_sample(in_tdata_i[31:0], in_tdata_i[63:32]));
    if (rst_ni && out_tvalid_o && out_tready_i) begin
      got = res_t'(out_tdata_o[37:0]);
      if (alarm_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata_o, '0);
      end else begin
        want = alarm_q.pop_front();
        if (out_tdata_o[39:38] != 2'b0) report_mismatch("pad", out_tdata_o, 40'(want));
        if (got.below_min != want.below_min)
          report_mismatch("below_min", out_tdata_o, 40'(want));
        if (got.above_max != want.above_max)
          report_mismatch("above_max", out_tdata_o, 40'(want));
        if (got.rate_exceeded != want.rate_exceeded)
          report_mismatch("rate_exceeded", out_tdata_o, 40'(want));
        if (got.predict_above_max != want.predict_above_max)
          report_mismatch("predict_above_max", out_tdata_o, 40'(want));
        if (got.predict_below_min != want.predict_below_min)
          report_mismatch("predict_below_min", out_tdata_o, 40'(want));
        if (got.prediction_valid != want.prediction_valid)
          report_mismatch("prediction_valid", out_tdata_o, 40'(want));
        if (got.predicted_value != want.predicted_value)
          report_mismatch("predicted_value", out_tdata_o, 40'(want));
      end
    end
  end

  task automatic set_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MIN_LIMIT: lo_lim = data;
      CFG_MAX_LIMIT: hi_lim = data;
      CFG_MAX_RATE:  rate_lim = data[30:0];
      CFG_LIMIT_EN:  chk_en = data[2:0];
      CFG_HORIZON:   horizon = data[19:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || in_tvalid_i || alarm_q.size() > 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic push(logic signed [31:0] v, logic [31:0] t);
    sample_t s;
    s.val = v;
    s.ts = t;
    sample_q.push_back(s);
  endtask

  task automatic random_run(int cnt);
    logic signed [31:0] base;
    logic signed [31:0] slope;
    int sel;
    base = $urandom;
    slope = $signed($urandom_range(20000)) - 10000;
    for (int i = 0; i < cnt; i++) begin
      sel = $urandom_range(99);
      if (sel < 4) now_ts = now_ts - $urandom_range(50);
      else if (sel < 8) now_ts = now_ts + $urandom_range(32'h3FFFFFF);
      else if (sel < 10) now_ts = $urandom;
      else now_ts = now_ts + $urandom_range(20);
      base = base + slope * $signed($urandom_range(4)) + $signed($urandom_range(2000)) - 1000;
      if ($urandom_range(99) < 12) push($urandom, now_ts);
      else push(base, now_ts);
      if ($urandom_range(99) < 5) slope = $signed($urandom_range(200000)) - 100000;
    end
  endtask

  task automatic random_cfg();
    logic signed [31:0] a, b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(3))
      0: begin set_reg(CFG_MIN_LIMIT, 32'h80000000); set_reg(CFG_MAX_LIMIT, 32'h7FFFFFFF); end
      1: begin set_reg(CFG_MIN_LIMIT, 32'h7FFFFFFF); set_reg(CFG_MAX_LIMIT, 32'h80000000); end
      default: begin
        set_reg(CFG_MIN_LIMIT, a < b ? a : b);
        set_reg(CFG_MAX_LIMIT, a < b ? b : a);
      end
    endcase
    case ($urandom_range(3))
      0: set_reg(CFG_MAX_RATE, 32'h0);
      1: set_reg(CFG_MAX_RATE, 32'hFFFFFFFF);
      default: set_reg(CFG_MAX_RATE, $urandom_range(32'h40000));
    endcase
    set_reg(CFG_LIMIT_EN, $urandom_range(7));
    case ($urandom_range(3))
      0: set_reg(CFG_HORIZON, 32'h0);
      1: set_reg(CFG_HORIZON, 32'hFFFFFFFF);
      default: set_reg(CFG_HORIZON, $urandom_range(5000));
    endcase
    set_reg(CFG_UNUSED, $urandom);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part with reset defaults first: no checks enabled.
    push(32'sh80000000, 32'd0);
    push(32'sh7FFFFFFF, 32'd10);
    push(32'sd0, 32'd20);
    push(32'sd65536, 32'd30);
    drain();
    set_reg(CFG_MIN_LIMIT, 32'hFFFF0000);
    set_reg(CFG_MAX_LIMIT, 32'h00010000);
    set_reg(CFG_MAX_RATE, 32'h00001000);
    set_reg(CFG_LIMIT_EN, 32'h7);
    set_reg(CFG_HORIZON, 32'd300);
    push(32'sh80000000, 32'd40);
    push(32'sh7FFFFFFF, 32'd41);
    push(32'sd0, 32'd41);
    push(32'sd100, 32'd30);
    push(32'sd200, 32'd50);
    push(32'sd300, 32'd60);
    push(32'sd400, 32'd70);
    push(32'sd500, 32'd80);
    drain();
    set_reg(CFG_HORIZON, 32'hFFFFF);
    push(32'sd10, 32'd80);
    push(32'sd10, 32'd80);
    push(32'sd10, 32'd80);
    push(32'sd65536, 32'hFFFFFFFF);
    push(-32'sd65536, 32'd5);
    push(32'sh7FFFFFFF, 32'hF0000000);
    push(32'sh80000000, 32'hFFFFFFFF);
    drain();
    now_ts = 32'd1000;

    for (int ph = 0; ph < 9; ph++) begin
      snd_idle = ph < 3 ? 7 : (ph < 6 ? 77 : 0);
      rcv_idle = ph < 3 ? 77 : (ph < 6 ? 7 : 0);
      random_cfg();
      random_run(40);
      if (ph == 4) drain();
      random_run(37);
      drain();
    end

    repeat (DRAIN_CYC) @(posedge clk_i);
    if (alarm_q.size() > 0) report_mismatch("missing beat", '0, 40'(alarm_q[0]));
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
